// ===== src/twg_pkg.sv =====
`timescale 1ns / 1ps
// twg_pkg: types, codes and defaults shared by the ternary-weight GEMM block.
// No dependencies.
package twg_pkg;

    localparam int DEF_MAX_INNER   = 1024;
    localparam int DEF_MAX_COLUMNS = 4096;

    localparam int INNER_W = 11;
    localparam int COLS_W  = 13;
    localparam int ROWS_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int SUM_W   = 19;
    localparam int COLIDX_W = 12;

    localparam logic [INNER_W-1:0] RST_INNER = 11'd64;
    localparam logic [COLS_W-1:0]  RST_COLS  = 13'd4;
    localparam logic [ROWS_W-1:0]  RST_ROWS  = 16'd1;

    localparam logic [CIDX_W-1:0] CFG_INNER_LENGTH = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_ROW_COUNT    = 2'd2;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;

    localparam logic [1:0] CODE_ADD = 2'b01;
    localparam logic [1:0] CODE_SUB = 2'b10;

    typedef struct packed {
        logic              command;
        logic signed [7:0] activation_0;
        logic signed [7:0] activation_1;
        logic signed [7:0] activation_2;
        logic signed [7:0] activation_3;
        logic [7:0]        weight_byte;
    } t_in_word;

    typedef struct packed {
        logic signed [SUM_W-1:0] dot_sum;
        logic [COLIDX_W-1:0]     column_index;
        logic                    row_done;
        logic                    matrix_done;
    } t_out_word;

    typedef struct packed {
        logic                store_wr;
        logic                store_rd;
        logic                acc_go;
        logic                col_last;
        logic [3:0]          lane_en;
        logic [COLIDX_W-1:0] column_index;
        logic                row_done;
        logic                matrix_done;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ===== src/twg_dp.sv =====
`timescale 1ns / 1ps
// twg_dp: activation store, ternary accumulator with saturation, output register.
// Depends on twg_pkg.
module twg_dp #(
    parameter int MAX_INNER = twg_pkg::DEF_MAX_INNER
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  twg_pkg::t_dp_cmd    i_cmd,
    input  logic [((((MAX_INNER+3)/4) > 1) ? $clog2((MAX_INNER+3)/4) : 1)-1:0] i_addr,
    input  twg_pkg::t_in_word   i_in_word,
    output twg_pkg::t_dp_status o_status,
    output logic                o_valid,
    input  logic                i_stall,
    output twg_pkg::t_out_word  o_out_word
);
    import twg_pkg::*;

    localparam int DEPTH = (MAX_INNER + 3) / 4;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0]             r_store [DEPTH];
    logic [31:0]             r_rd_data;
    logic [7:0]              r_wbyte;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic                    r_out_valid;
    t_out_word               r_out;
    logic                    out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr) begin
            r_store[i_addr[PW-1:0]] <= {i_in_word.activation_3, i_in_word.activation_2,
                                        i_in_word.activation_1, i_in_word.activation_0};
        end
        if (i_cmd.store_rd) begin
            r_rd_data <= r_store[i_addr[PW-1:0]];
            r_wbyte   <= i_in_word.weight_byte;
        end
    end

    // four add/sub/skip steps, each clamped to the sum range
    always_comb begin
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W:0]   t;
        logic signed [7:0]       a;
        logic [1:0]              code;
        s = r_sum;
        for (int i = 0; i < 4; i++) begin
            a    = r_rd_data[8*i +: 8];
            code = r_wbyte[2*i +: 2];
            t    = {s[SUM_W-1], s};
            if (i_cmd.lane_en[i]) begin
                if (code == CODE_ADD) begin
                    t = {s[SUM_W-1], s} + (SUM_W+1)'(a);
                end else if (code == CODE_SUB) begin
                    t = {s[SUM_W-1], s} - (SUM_W+1)'(a);
                end
            end
            if (t[SUM_W] != t[SUM_W-1]) begin
                s = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                s = t[SUM_W-1:0];
            end
        end
        n_sum = s;
    end

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc_go) begin
                if (!i_cmd.col_last) begin
                    r_sum <= n_sum;
                end else if (out_free) begin
                    r_sum <= '0;
                end
            end
            if (i_cmd.acc_go && i_cmd.col_last && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_go && i_cmd.col_last && out_free) begin
            r_out.dot_sum      <= n_sum;
            r_out.column_index <= i_cmd.column_index;
            r_out.row_done     <= i_cmd.row_done;
            r_out.matrix_done  <= i_cmd.matrix_done;
        end
    end

    assign o_status.out_free = out_free;
    assign o_valid           = r_out_valid;
    assign o_out_word        = r_out;

endmodule

// ===== src/twg_ctrl.sv =====
`timescale 1ns / 1ps
// twg_ctrl: config registers, load/weight/column/row counters and the item FSM.
// Depends on twg_pkg.
module twg_ctrl #(
    parameter int MAX_INNER   = twg_pkg::DEF_MAX_INNER,
    parameter int MAX_COLUMNS = twg_pkg::DEF_MAX_COLUMNS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [twg_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [twg_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    input  logic                        i_command,
    output logic                        o_stall,
    output twg_pkg::t_dp_cmd            o_cmd,
    output logic [((((MAX_INNER+3)/4) > 1) ? $clog2((MAX_INNER+3)/4) : 1)-1:0] o_addr,
    input  twg_pkg::t_dp_status         i_status
);
    import twg_pkg::*;

    localparam int DEPTH = (MAX_INNER + 3) / 4;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = $clog2(MAX_INNER + 1);
    localparam int CMAX  = (MAX_COLUMNS > 8191) ? 8191 : MAX_COLUMNS;
    localparam int CW    = (CMAX > 1) ? $clog2(CMAX) : 1;
    localparam int EW    = $clog2(CMAX + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_ACC  = 1'b1;

    logic               r_state;
    logic [INNER_W-1:0] r_inner;
    logic [COLS_W-1:0]  r_cols;
    logic [ROWS_W-1:0]  r_rows;
    logic [PW-1:0]      r_lpos;
    logic [PW-1:0]      r_wpos;
    logic [CW-1:0]      r_col;
    logic [ROWS_W-1:0]  r_row;

    logic [3:0]          r_lane_en;
    logic                r_last;
    logic [COLIDX_W-1:0] r_colidx;
    logic                r_row_done;
    logic                r_mat_done;

    logic [KW-1:0]     eff_k;
    logic [KW-1:0]     groups;
    logic [EW-1:0]     eff_cols;
    logic [ROWS_W-1:0] eff_rows;
    logic [PW-1:0]     lpos;
    logic              accept;
    logic              last_group;
    logic              row_last;
    logic              mat_last;
    logic [3:0]        n_lane;

    always_comb begin
        if (r_inner == '0) begin
            eff_k = KW'(1);
        end else if (32'(r_inner) > 32'(MAX_INNER)) begin
            eff_k = KW'(MAX_INNER);
        end else begin
            eff_k = KW'(r_inner);
        end
        if (r_cols == '0) begin
            eff_cols = EW'(1);
        end else if (32'(r_cols) > 32'(CMAX)) begin
            eff_cols = EW'(CMAX);
        end else begin
            eff_cols = EW'(r_cols);
        end
        eff_rows = (r_rows == '0) ? ROWS_W'(1) : r_rows;
        groups   = KW'((32'(eff_k) + 32'd3) >> 2);
    end

    assign lpos       = (32'(r_lpos) >= 32'(groups)) ? '0 : r_lpos;
    assign last_group = (32'(r_wpos) + 32'd1) >= 32'(groups);
    assign row_last   = (32'(r_col) + 32'd1) >= 32'(eff_cols);
    assign mat_last   = row_last && ((32'(r_row) + 32'd1) >= 32'(eff_rows));

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_lane[i] = (32'(r_wpos) < 32'(groups))
                     && (((32'(r_wpos) << 2) + 32'(i)) < 32'(eff_k));
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= RST_INNER;
            r_cols  <= RST_COLS;
            r_rows  <= RST_ROWS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INNER_LENGTH: r_inner <= i_cfg_wdata[INNER_W-1:0];
                CFG_COLUMN_COUNT: r_cols  <= i_cfg_wdata[COLS_W-1:0];
                CFG_ROW_COUNT:    r_rows  <= i_cfg_wdata[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lpos  <= '0;
            r_wpos  <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_command == CMD_LOAD) begin
                        r_lpos <= ((32'(lpos) + 32'd1) >= 32'(groups)) ? '0 : lpos + 1'b1;
                    end else if (accept) begin
                        r_state <= S_ACC;
                        if (!last_group) begin
                            r_wpos <= r_wpos + 1'b1;
                        end else begin
                            r_wpos <= '0;
                            if (row_last) begin
                                r_col  <= '0;
                                r_lpos <= '0;
                                r_row  <= mat_last ? '0 : r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end
                    end
                end
                S_ACC: begin
                    if (!r_last || i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_command == CMD_WEIGHT) begin
            r_lane_en  <= n_lane;
            r_last     <= last_group;
            r_colidx   <= COLIDX_W'(r_col);
            r_row_done <= row_last;
            r_mat_done <= mat_last;
        end
    end

    always_comb begin
        o_cmd.store_wr     = accept && (i_command == CMD_LOAD);
        o_cmd.store_rd     = accept && (i_command == CMD_WEIGHT);
        o_cmd.acc_go       = (r_state == S_ACC);
        o_cmd.col_last     = r_last;
        o_cmd.lane_en      = r_lane_en;
        o_cmd.column_index = r_colidx;
        o_cmd.row_done     = r_row_done;
        o_cmd.matrix_done  = r_mat_done;
        o_addr             = (i_command == CMD_WEIGHT) ? r_wpos : lpos;
    end

endmodule

// ===== src/ternary_weight_gemm_top.sv =====
`timescale 1ns / 1ps
// Ternary-weight GEMM: int8 activation rows times 2-bit packed ternary weights.
// Input channel (i_valid/o_stall, i_in_word): command 0 loads four activations
// into the next store group, command 1 supplies one packed weight byte of the
// current column. Output channel (o_valid/i_stall, o_out_word): one word per
// finished column with its sum, column index and end-of-row/matrix flags.
// Config: write inner_length, column_count, row_count through i_cfg_we /
// i_cfg_index / i_cfg_wdata while idle.
// Load words can be taken back to back; each weight word stalls the input for the
// accumulate step, which follows the registered read of the activation store.
// A column's last weight word passes the store read register and the accumulate
// state into the output register; o_valid rises as that register is loaded.
// If the receiver stalls, the result waits in the output register; further
// words are still taken until another finished column needs that register.
// Reset restores the default registers and clears all counters and the sum;
// store contents are undefined until loaded. No clearing pass is needed.
// Depends on twg_pkg, twg_ctrl, twg_dp.
module ternary_weight_gemm_top #(
    parameter int MAX_INNER   = twg_pkg::DEF_MAX_INNER,
    parameter int MAX_COLUMNS = twg_pkg::DEF_MAX_COLUMNS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [twg_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [twg_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  twg_pkg::t_in_word          i_in_word,
    output logic                       o_valid,
    input  logic                       i_stall,
    output twg_pkg::t_out_word         o_out_word
);
    import twg_pkg::*;

    localparam int DEPTH = (MAX_INNER + 3) / 4;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic [PW-1:0] dp_addr;

    twg_ctrl #(
        .MAX_INNER   (MAX_INNER),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_command   (i_in_word.command),
        .o_stall     (o_stall),
        .o_cmd       (dp_cmd),
        .o_addr      (dp_addr),
        .i_status    (dp_status)
    );

    twg_dp #(
        .MAX_INNER (MAX_INNER)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_addr     (dp_addr),
        .i_in_word  (i_in_word),
        .o_status   (dp_status),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_word (o_out_word)
    );

    a_mat_implies_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_out_word.matrix_done || o_out_word.row_done))
        else $error("matrix_done without row_done");

    a_weight_blocks_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_in_word.command == CMD_WEIGHT) |=> o_stall)
        else $error("weight word not followed by accumulate cycle");

    a_result_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without accumulate cycle");

endmodule

// ===== tb/ternary_weight_gemm_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for ternary_weight_gemm_top: streams activation loads and packed ternary weight
// bytes, predicts every column sum in a scoreboard and checks each output word against it.
// Depends on twg_pkg and the ternary_weight_gemm_top RTL.
module ternary_weight_gemm_top_tb;
    import twg_pkg::*;

    localparam int STORE_DEPTH = (DEF_MAX_INNER + 3) / 4;
    localparam int SUM_HI = 2 ** (SUM_W - 1) - 1;
    localparam int SUM_LO = -(2 ** (SUM_W - 1));
    localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1000;
    localparam int CALM_ITEMS = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int DRAIN_LIMIT = 20000;
    localparam int MAX_PRINTS = 40;
    localparam int OPEN_COLUMNS = 8;
    localparam longint TIMEOUT_NS = 64'd30_000_000;

    class gemm_scoreboard;
        logic [INNER_W-1:0] inner_reg;
        logic [COLS_W-1:0]  cols_reg;
        logic [ROWS_W-1:0]  rows_reg;
        logic [31:0]        act_store [STORE_DEPTH];
        int                 load_pos;
        int                 weight_pos;
        int                 acc;
        int                 col;
        int                 row;
        t_out_word          sums_due [$];
        int                 errors;

        function new();
            inner_reg  = RST_INNER;
            cols_reg   = RST_COLS;
            rows_reg   = RST_ROWS;
            load_pos   = 0;
            weight_pos = 0;
            acc        = 0;
            col        = 0;
            row        = 0;
            errors     = 0;
            foreach (act_store[i]) act_store[i] = '0;
        endfunction

        function int eff_inner();
            if (inner_reg == 0) return 1;
            if (inner_reg > DEF_MAX_INNER) return DEF_MAX_INNER;
            return int'(inner_reg);
        endfunction

        function int eff_cols();
            if (cols_reg == 0) return 1;
            if (cols_reg > DEF_MAX_COLUMNS) return DEF_MAX_COLUMNS;
            return int'(cols_reg);
        endfunction

        function int eff_rows();
            return (rows_reg == 0) ? 1 : int'(rows_reg);
        endfunction

        function int pending();
            return sums_due.size();
        endfunction

        function void write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
            case (idx)
                CFG_INNER_LENGTH: inner_reg = data[INNER_W-1:0];
                CFG_COLUMN_COUNT: cols_reg  = data[COLS_W-1:0];
                CFG_ROW_COUNT:    rows_reg  = data[ROWS_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(input t_in_word w);
            int          k;
            int          groups;
            int          pos;
            int          s;
            int          a;
            int          i;
            logic [31:0] word;
            logic [1:0]  code;
            bit          row_last;
            bit          mat_last;
            t_out_word   r;
            k = eff_inner();
            groups = (k + 3) / 4;
            if (w.command == CMD_LOAD) begin
                pos = (load_pos >= groups) ? 0 : load_pos;
                act_store[pos] = {w.activation_3, w.activation_2, w.activation_1, w.activation_0};
                load_pos = (pos + 1 >= groups) ? 0 : pos + 1;
                return;
            end
            pos = weight_pos;
            word = act_store[pos];
            s = acc;
            for (i = 0; i < 4; i++) begin
                code = w.weight_byte[2*i +: 2];
                a = $signed(word[8*i +: 8]);
                if (pos < groups && pos * 4 + i < k) begin
                    if (code == CODE_ADD) s += a;
                    else if (code == CODE_SUB) s -= a;
                    if (s > SUM_HI) s = SUM_HI;
                    if (s < SUM_LO) s = SUM_LO;
                end
            end
            if (pos + 1 < groups) begin
                acc = s;
                weight_pos = pos + 1;
                return;
            end
            row_last = (col + 1 >= eff_cols());
            mat_last = row_last && (row + 1 >= eff_rows());
            r.dot_sum      = s[SUM_W-1:0];
            r.column_index = col[COLIDX_W-1:0];
            r.row_done     = row_last;
            r.matrix_done  = mat_last;
            sums_due.push_back(r);
            acc = 0;
            weight_pos = 0;
            if (row_last) begin
                col = 0;
                load_pos = 0;
                row = mat_last ? 0 : ((row + 1) & 16'hFFFF);
            end else begin
                col = col + 1;
            end
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("%s", msg);
        endtask

        task check_result(input t_out_word got);
            t_out_word want;
            if (sums_due.size() == 0) begin
                report($sformatf("unexpected word: sum %0d column %0d", got.dot_sum,
                    got.column_index));
                return;
            end
            want = sums_due.pop_front();
            if (got.dot_sum !== want.dot_sum)
                report($sformatf("column %0d: sum %0d, want %0d", want.column_index,
                    got.dot_sum, want.dot_sum));
            if (got.column_index !== want.column_index)
                report($sformatf("column index %0d, want %0d", got.column_index,
                    want.column_index));
            if (got.row_done !== want.row_done)
                report($sformatf("column %0d: row_done %b, want %b", want.column_index,
                    got.row_done, want.row_done));
            if (got.matrix_done !== want.matrix_done)
                report($sformatf("column %0d: matrix_done %b, want %b", want.column_index,
                    got.matrix_done, want.matrix_done));
        endtask

        task leftover_check();
            if (sums_due.size() != 0)
                report($sformatf("%0d column sums never arrived", sums_due.size()));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    t_in_word          i_in_word = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    t_out_word         o_out_word;

    gemm_scoreboard sb;
    bit             calm = 1'b0;
    int             hold_asked = 0;
    int             random_sent = 0;
    int             phase_budget = -1;

    ternary_weight_gemm_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_word   (i_in_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_in_word random_word(input logic cmd);
        logic [63:0] bits;
        t_in_word    w;
        bits = {$urandom, $urandom};
        w = bits[$bits(t_in_word)-1:0];
        w.command = cmd;
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        i_valid   <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(w);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send_load(input logic signed [7:0] a0, input logic signed [7:0] a1,
                             input logic signed [7:0] a2, input logic signed [7:0] a3);
        t_in_word w;
        w = random_word(CMD_LOAD);
        w.activation_0 = a0;
        w.activation_1 = a1;
        w.activation_2 = a2;
        w.activation_3 = a3;
        send_word(w);
    endtask

    task automatic send_weight(input logic [7:0] b);
        t_in_word w;
        w = random_word(CMD_WEIGHT);
        w.weight_byte = b;
        send_word(w);
    endtask

    task automatic stream_word(input logic cmd);
        if (phase_budget == 0) return;
        if ($urandom_range(0, 11) == 0) begin
            send_word(random_word(($urandom_range(0, 1) == 1) ? CMD_WEIGHT : CMD_LOAD));
            random_sent++;
        end
        send_word(random_word(cmd));
        random_sent++;
        if (phase_budget > 0) phase_budget--;
        calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_sizes(input logic [CFG_W-1:0] vi, input logic [CFG_W-1:0] vc,
                                 input logic [CFG_W-1:0] vr);
        logic [CFG_W-1:0] spare;
        spare = CFG_W'($urandom);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_INNER_LENGTH;
        i_cfg_wdata <= vi;
        @(posedge i_clk);
        sb.write_reg(CFG_INNER_LENGTH, vi);
        i_cfg_index <= CFG_COLUMN_COUNT;
        i_cfg_wdata <= vc;
        @(posedge i_clk);
        sb.write_reg(CFG_COLUMN_COUNT, vc);
        i_cfg_index <= CFG_ROW_COUNT;
        i_cfg_wdata <= vr;
        @(posedge i_clk);
        sb.write_reg(CFG_ROW_COUNT, vr);
        i_cfg_index <= CFG_SPARE;
        i_cfg_wdata <= spare;
        @(posedge i_clk);
        sb.write_reg(CFG_SPARE, spare);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input bit squeeze);
        int               pick;
        int               groups;
        int               cols;
        int               rows;
        int               r;
        int               g;
        logic [CFG_W-1:0] vi;
        logic [CFG_W-1:0] vc;
        logic [CFG_W-1:0] vr;
        pick = $urandom_range(0, 39);
        vi = CFG_W'($urandom_range(1, 24));
        vc = CFG_W'($urandom_range(1, 5));
        vr = CFG_W'($urandom_range(1, 3));
        case (pick)
            0: begin
                vi = CFG_W'($urandom_range(600, DEF_MAX_INNER));
                vc = CFG_W'(1);
                vr = CFG_W'(1);
            end
            1: vi = '0;
            2: vc = '0;
            3: vr = '0;
            4: vr = CFG_W'($urandom_range(4, 65535));
            default: ;
        endcase
        if (squeeze) begin
            vi = CFG_W'($urandom_range(1, 4));
            vc = CFG_W'(4);
            vr = CFG_W'(3);
        end
        // bits above each register width are dropped by the block
        vi[CFG_W-1:INNER_W] = (CFG_W-INNER_W)'($urandom);
        vc[CFG_W-1:COLS_W] = (CFG_W-COLS_W)'($urandom);
        wait_idle();
        program_sizes(vi, vc, vr);
        groups = (sb.eff_inner() + 3) / 4;
        cols = (sb.eff_cols() < 6) ? sb.eff_cols() : 6;
        rows = (sb.eff_rows() < 3) ? sb.eff_rows() : 3;
        // a cut stream leaves a half-done column or row for the next sizes
        phase_budget = ($urandom_range(0, 5) == 0)
            ? $urandom_range(1, groups * (cols + 1) * rows) : -1;
        if (squeeze) hold_asked++;
        for (r = 0; r < rows; r++) begin
            for (g = 0; g < groups; g++) stream_word(CMD_LOAD);
            repeat (cols * groups) stream_word(CMD_WEIGHT);
        end
    endtask

    initial begin : receiver
        int left;
        int hold_served;
        bit stall_now;
        left = 0;
        hold_served = 0;
        stall_now = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) sb.check_result(o_out_word);
            if (left > 0) left--;
            if (left == 0) begin
                if (hold_asked != hold_served) begin
                    hold_served = hold_asked;
                    left = HOLD_CYCLES;
                    stall_now = 1'b1;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    left = $urandom_range(1, 18);
                    stall_now = 1'b1;
                end else begin
                    stall_now = 1'b0;
                end
            end
            i_stall <= stall_now;
        end
    end

    initial begin : timeout
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int n;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes: 64 activations, 4 columns, 1 row
        repeat (16) send_word(random_word(CMD_LOAD));
        repeat (64) send_word(random_word(CMD_WEIGHT));

        // longest rows fill the whole store; all -128 gives sums of both signs
        wait_idle();
        program_sizes(16'hFFFF, 16'd2, 16'd1);
        repeat (STORE_DEPTH) send_load(-128, -128, -128, -128);
        repeat (STORE_DEPTH) send_weight(8'h55);
        repeat (STORE_DEPTH) send_weight(8'hAA);

        // five activations: second group uses lane 0 only
        wait_idle();
        program_sizes(16'd5, 16'd2, 16'd2);
        send_load(-128, 127, -1, 0);
        send_load(127, -128, 1, 55);
        send_load(3, -7, 100, -100);
        send_weight(8'h55);
        send_weight(8'hFF);
        send_weight(8'hAA);
        send_weight(8'h66);
        send_load(-128, -128, -128, -128);
        send_load(127, 127, 127, 127);
        send_weight(8'h00);
        send_weight(8'h99);
        send_weight(8'h5A);
        send_weight(8'hA5);
        send_load(1, 2, 3, 4);
        send_load(-5, -6, -7, -8);
        send_weight(8'h01);
        // length grows in the middle of a column
        wait_idle();
        program_sizes(16'd12, 16'd2, 16'd2);
        send_weight(8'hFF);
        send_weight(8'h96);

        // column count beyond the maximum; the row is left open
        wait_idle();
        program_sizes(16'h2804, 16'hFFFF, 16'd1);
        send_word(random_word(CMD_LOAD));
        repeat (OPEN_COLUMNS) send_word(random_word(CMD_WEIGHT));

        // zero length clamps to one; open column is past the new count;
        // tallest matrix left unfinished
        wait_idle();
        program_sizes(16'h0000, 16'd2, 16'hFFFF);
        repeat (3) begin
            send_word(random_word(CMD_LOAD));
            repeat (2) send_word(random_word(CMD_WEIGHT));
        end

        n = 0;
        while (random_sent < RANDOM_ITEMS) begin
            random_phase(n == 2);
            n++;
        end
        phase_budget = -1;
        i_valid <= 1'b0;

        n = 0;
        while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.leftover_check();
        if (sb.errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
